[src/nge_pkg.sv]
`default_nettype none

package nge_pkg;

    localparam int VALUE_BITS_DEF  = 10;
    localparam int STACK_DEPTH_DEF = 1024;
    localparam int OP_BITS         = 2;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_AW        = $clog2(QUEUE_DEPTH);

    typedef enum logic [OP_BITS-1:0] {
        OP_SEQ   = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SEQ,
        B_QUERY,
        B_CLEAR
    } back_state_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic avail;
        op_t  op;
    } q_head_t;

    // back end status toward the front end
    typedef struct packed {
        logic deq;
        logic init;
    } back_stat_t;

endpackage

`default_nettype wire

[src/next_greater_element_engine_top.sv]
// Next-greater-element engine, monotonic stack.
// Request channel: op/value taken on a rising edge with start high and busy
// low. op 0 feeds a sequence value, op 1 queries a key, op 2 clears stack,
// table and overflow flag; op 3 is ignored. Requests go into a 4-entry queue,
// so busy rises only when the queue is full or during the reset sweep.
// Result channel: only queries give a result; done is high for one cycle with
// next_greater (-1 if no value recorded) and overflow (sticky since clear).
// There is no backpressure: the receiver must take every done cycle.
// Per request the back end dequeues it in B_IDLE, then handles it as follows:
//   query     B_QUERY reads the table entry; the result is registered after it
//   sequence  B_SEQ pops each smaller value (each value popped at most once), then pushes
//   clear     B_CLEAR sweeps every table entry, clearing the table valid bits
// Reset: stack and flag cleared at once, then a B_CLEAR sweep over all entries
// clears the table valid bits with busy held high.
`default_nettype none

module next_greater_element_engine_top #(
    parameter int VALUE_BITS  = nge_pkg::VALUE_BITS_DEF,
    parameter int STACK_DEPTH = nge_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [nge_pkg::OP_BITS-1:0]  op,
    input  wire logic [VALUE_BITS-1:0]        value,
    output logic                              done,
    output logic signed [VALUE_BITS:0]        next_greater,
    output logic                              overflow
);

    nge_pkg::q_head_t      head;
    nge_pkg::back_stat_t   stat;
    logic [VALUE_BITS-1:0] head_value;

    nge_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .op         (op),
        .value      (value),
        .busy       (busy),
        .head       (head),
        .head_value (head_value),
        .stat       (stat)
    );

    nge_back #(
        .VALUE_BITS  (VALUE_BITS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .head_value   (head_value),
        .stat         (stat),
        .done         (done),
        .next_greater (next_greater),
        .overflow     (overflow)
    );

endmodule

`default_nettype wire

[src/nge_ram.sv]
`default_nettype none

module nge_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[src/nge_front.sv]
`default_nettype none

module nge_front #(
    parameter int VALUE_BITS = nge_pkg::VALUE_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [nge_pkg::OP_BITS-1:0]   op,
    input  wire logic [VALUE_BITS-1:0]         value,
    output logic                               busy,
    output nge_pkg::q_head_t                   head,
    output logic      [VALUE_BITS-1:0]         head_value,
    input  wire nge_pkg::back_stat_t           stat
);

    localparam int QD  = nge_pkg::QUEUE_DEPTH;
    localparam int QAW = nge_pkg::QUEUE_AW;

    nge_pkg::op_t    q_op_reg  [QD];
    logic [VALUE_BITS-1:0] q_val_reg [QD];
    logic [QAW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]    cnt_reg, cnt_next;
    logic            accept;
    logic            enq;
    logic            full;

    assign full   = (cnt_reg == (QAW+1)'(QD));
    assign busy   = full || stat.init;
    assign accept = start && !busy;
    // unused op code is dropped here
    assign enq    = accept && (op inside {nge_pkg::OP_SEQ, nge_pkg::OP_QUERY,
                                          nge_pkg::OP_CLEAR});

    assign head.avail = (cnt_reg != '0);
    assign head.op    = q_op_reg[rd_ptr_reg];
    assign head_value = q_val_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (enq)
        begin
            wr_ptr_next = wr_ptr_reg + QAW'(1);
        end
        if (stat.deq)
        begin
            rd_ptr_next = rd_ptr_reg + QAW'(1);
        end
        case ({enq, stat.deq})
            2'b10:   cnt_next = cnt_reg + (QAW+1)'(1);
            2'b01:   cnt_next = cnt_reg - (QAW+1)'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_op_reg[wr_ptr_reg]  <= nge_pkg::op_t'(op);
            q_val_reg[wr_ptr_reg] <= value;
        end
    end

`ifndef SYNTHESIS
    a_no_deq_empty: assert property (@(posedge clk) disable iff (!rst_n)
        stat.deq |-> (cnt_reg != '0))
        else $error("dequeue from empty queue");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (QAW+1)'(QD))
        else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

[src/nge_back.sv]
`default_nettype none

module nge_back #(
    parameter int VALUE_BITS  = nge_pkg::VALUE_BITS_DEF,
    parameter int STACK_DEPTH = nge_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire nge_pkg::q_head_t              head,
    input  wire logic [VALUE_BITS-1:0]         head_value,
    output nge_pkg::back_stat_t                stat,
    output logic                               done,
    output logic signed [VALUE_BITS:0]         next_greater,
    output logic                               overflow
);

    localparam int KEY_COUNT = 1 << VALUE_BITS;
    localparam int CW        = $clog2(STACK_DEPTH + 1);
    localparam int SAW       = $clog2(STACK_DEPTH);

    nge_pkg::back_state_t state_reg, state_next;

    logic [VALUE_BITS-1:0] cur_val_reg, cur_val_next;
    logic [VALUE_BITS-1:0] top_reg, top_next;
    logic                  load_pend_reg, load_pend_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  ovf_reg, ovf_next;
    logic [VALUE_BITS-1:0] sweep_reg, sweep_next;
    logic                  init_reg, init_next;
    logic                  done_reg, done_next;
    logic [VALUE_BITS:0]   ng_reg, ng_next;
    logic                  ovf_out_reg, ovf_out_next;

    logic                  stk_we;
    logic [SAW-1:0]        stk_waddr;
    logic [SAW-1:0]        stk_raddr;
    logic [VALUE_BITS-1:0] stk_rdata;
    logic                  tbl_we;
    logic [VALUE_BITS-1:0] tbl_waddr;
    logic [VALUE_BITS:0]   tbl_wdata;
    logic [VALUE_BITS:0]   tbl_rdata;

    logic [CW-1:0]         cnt_m2;
    logic [VALUE_BITS-1:0] top_cur;
    logic                  do_pop;
    logic                  full;

    assign cnt_m2    = count_reg - CW'(2);
    assign stk_raddr = cnt_m2[SAW-1:0];
    assign stk_waddr = count_reg[SAW-1:0];
    assign top_cur   = load_pend_reg ? stk_rdata : top_reg;
    assign do_pop    = (count_reg != '0) && (top_cur < cur_val_reg);
    assign full      = (count_reg == CW'(STACK_DEPTH));

    nge_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (cur_val_reg),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // entry = {valid, next greater value}
    nge_ram #(
        .WIDTH (VALUE_BITS + 1),
        .DEPTH (KEY_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (head_value),
        .rdata (tbl_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nge_pkg::B_IDLE:
            begin
                if (head.avail)
                begin
                    case (head.op)
                        nge_pkg::OP_SEQ:   state_next = nge_pkg::B_SEQ;
                        nge_pkg::OP_QUERY: state_next = nge_pkg::B_QUERY;
                        nge_pkg::OP_CLEAR: state_next = nge_pkg::B_CLEAR;
                        default:           state_next = nge_pkg::B_IDLE;
                    endcase
                end
            end
            nge_pkg::B_SEQ:
            begin
                if (!do_pop)
                begin
                    state_next = nge_pkg::B_IDLE;
                end
            end
            nge_pkg::B_QUERY:
            begin
                state_next = nge_pkg::B_IDLE;
            end
            nge_pkg::B_CLEAR:
            begin
                if (sweep_reg == '1)
                begin
                    state_next = nge_pkg::B_IDLE;
                end
            end
            default: state_next = nge_pkg::B_IDLE;
        endcase
    end

    always_comb
    begin
        cur_val_next   = cur_val_reg;
        top_next       = top_reg;
        load_pend_next = load_pend_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        sweep_next     = sweep_reg;
        init_next      = init_reg;
        done_next      = 1'b0;
        ng_next        = ng_reg;
        ovf_out_next   = ovf_out_reg;
        stk_we         = 1'b0;
        tbl_we         = 1'b0;
        tbl_waddr      = sweep_reg;
        tbl_wdata      = '0;
        stat.deq       = 1'b0;
        stat.init      = init_reg;
        case (state_reg)
            nge_pkg::B_IDLE:
            begin
                if (head.avail)
                begin
                    stat.deq     = 1'b1;
                    cur_val_next = head_value;
                    if (head.op == nge_pkg::OP_CLEAR)
                    begin
                        count_next     = '0;
                        ovf_next       = 1'b0;
                        load_pend_next = 1'b0;
                        sweep_next     = '0;
                    end
                end
            end
            nge_pkg::B_SEQ:
            begin
                if (do_pop)
                begin
                    tbl_we         = 1'b1;
                    tbl_waddr      = top_cur;
                    tbl_wdata      = {1'b1, cur_val_reg};
                    count_next     = count_reg - CW'(1);
                    load_pend_next = 1'b1;
                end
                else if (!full)
                begin
                    stk_we         = 1'b1;
                    count_next     = count_reg + CW'(1);
                    top_next       = cur_val_reg;
                    load_pend_next = 1'b0;
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            nge_pkg::B_QUERY:
            begin
                done_next    = 1'b1;
                ng_next      = tbl_rdata[VALUE_BITS] ? {1'b0, tbl_rdata[VALUE_BITS-1:0]} : '1;
                ovf_out_next = ovf_reg;
            end
            nge_pkg::B_CLEAR:
            begin
                tbl_we     = 1'b1;
                sweep_next = sweep_reg + VALUE_BITS'(1);
                if (sweep_reg == '1)
                begin
                    init_next = 1'b0;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nge_pkg::B_CLEAR;
            load_pend_reg <= 1'b0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            sweep_reg     <= '0;
            init_reg      <= 1'b1;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            load_pend_reg <= load_pend_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            sweep_reg     <= sweep_next;
            init_reg      <= init_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_val_reg <= cur_val_next;
        top_reg     <= top_next;
        ng_reg      <= ng_next;
        ovf_out_reg <= ovf_out_next;
    end

    assign done         = done_reg;
    assign next_greater = ng_reg;
    assign overflow     = ovf_out_reg;

`ifndef SYNTHESIS
    a_done_after_query: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == nge_pkg::B_QUERY))
        else $error("result without query");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count out of range");

    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        stk_we |-> !tbl_we)
        else $error("push and table write in one cycle");

    a_init_no_deq: assert property (@(posedge clk) disable iff (!rst_n)
        init_reg |-> !stat.deq)
        else $error("dequeue during initial table sweep");
`endif

endmodule

`default_nettype wire
